[rtl/core/fupa_pkg.sv]
// Package for the fixed unit pool allocator: field widths, register indexes,
// command and status codes, reset values and the sequencer state type.
// No dependencies; imported by fixed_unit_pool_allocator.
package fupa_pkg;

   // Field and register widths.
   localparam int ADDR_W     = 15;
   localparam int SPAN_W     = 12;   // log2 of the byte span of one block
   localparam int CNT_CFG_W  = 9;
   localparam int USZ_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Default pool geometry.
   localparam int MAX_BLOCKS_DEF = 8;
   localparam int MAX_UNITS_DEF  = 256;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SIZE  = 2'd2;

   // Configuration reset values and unit size limits.
   localparam logic [CNT_CFG_W-1:0] INIT_COUNT_RST = 9'd3;
   localparam logic [CNT_CFG_W-1:0] GROW_COUNT_RST = 9'd3;
   localparam logic [USZ_W-1:0]     UNIT_SIZE_RST  = 5'd4;
   localparam logic [USZ_W-1:0]     USZ_MIN        = 5'd2;
   localparam logic [USZ_W-1:0]     USZ_MAX        = 5'd16;

   // Request commands.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_FOREIGN   = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_OPEN_FILL,
      S_OPEN_WR,
      S_ALLOC_RD,
      S_ALLOC_LINK,
      S_ALLOC_WB,
      S_FREE_CHK,
      S_FREE_DIV,
      S_FREE_WB
   } fsm_state_type;

endpackage

[rtl/core/fixed_unit_pool_allocator.sv]
// Fixed unit pool allocator: block table and free-list link memories with a
// read, modify and write-back sequencer and a bit-serial offset divider.
// Depends on fupa_pkg.
//
// Usage: a request is taken when start is high and busy is low. req_command
// selects allocate or free; req_address names the unit to free. Every request
// gives exactly one response, shown for one cycle with rsp_valid high; the
// receiver cannot stall it. Configuration writes go through csr_valid and
// csr_ready (always ready) and must be made while busy is low and no response
// is pending.
// Steps from accept to rsp_valid:
//   allocate from an open block: block read, link read, write back;
//   allocate that opens a block: the link memory is filled for the new
//     block's units one entry per cycle, then block write and the allocate steps;
//   free: block check, then the one-bit-per-cycle divider that turns the
//     byte offset into a unit index, then write back;
//   free refused by the block's byte bound or its free count: answered after the check;
//   exhausted pool or a block number that is not open: answered from idle.
// The next request can be taken in the cycle its predecessor's response shows.
// Reset empties the pool (no blocks open) and loads the register defaults;
// the memories need no clearing, since a block's links are written when the
// block opens.
module fixed_unit_pool_allocator
   import fupa_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int MAX_UNITS  = MAX_UNITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [ADDR_W-1:0]     req_address,
   // Response channel
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_unit_address,
   output logic [1:0]            rsp_status,
   // Configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BO_W       = $clog2(MAX_BLOCKS + 1);
   localparam int UNIT_W     = $clog2(MAX_UNITS);
   localparam int CNT_W      = $clog2(MAX_UNITS + 1);
   localparam int LINK_DEPTH = MAX_BLOCKS << UNIT_W;
   localparam int LA_W       = BLK_W + UNIT_W;
   localparam int BE_W       = UNIT_W + 2 * CNT_W;
   localparam int PROD_W     = CNT_W + USZ_W;
   localparam int DSR_W      = USZ_W + UNIT_W;
   localparam int REM_W      = (DSR_W > SPAN_W) ? DSR_W : SPAN_W;
   localparam int STEP_W     = $clog2(UNIT_W + 1);
   localparam int ABLK_W     = ADDR_W - SPAN_W;

   // Configuration registers
   logic [CNT_CFG_W-1:0] init_count_ff;
   logic [CNT_CFG_W-1:0] grow_count_ff;
   logic [USZ_W-1:0]     unit_size_ff;

   // Sequencer and pool state
   fsm_state_type        state_ff, state_in;
   logic [BLK_W-1:0]     blk_ff, blk_in;
   logic [BO_W-1:0]      bo_ff, bo_in;
   logic [MAX_BLOCKS-1:0] has_free_ff, has_free_in;
   logic [SPAN_W-1:0]    off_ff, off_in;
   logic [CNT_W-1:0]     units_ff, units_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [UNIT_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [ADDR_W-1:0]    ua_ff, ua_in;

   // Response registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   // Memories and their ports
   logic [UNIT_W-1:0]    link_mem_ff [LINK_DEPTH];
   logic [BE_W-1:0]      blk_mem_ff [MAX_BLOCKS];
   logic [UNIT_W-1:0]    link_rd_ff;
   logic [BE_W-1:0]      blk_rd_ff;
   logic                 link_we;
   logic [LA_W-1:0]      link_wa;
   logic [UNIT_W-1:0]    link_wd;
   logic [LA_W-1:0]      link_ra;
   logic                 blk_we;
   logic [BE_W-1:0]      blk_wd;
   logic [BLK_W-1:0]     blk_ra;

   // Decoded block entry and helpers
   logic [UNIT_W-1:0]    rd_head;
   logic [CNT_W-1:0]     rd_free;
   logic [CNT_W-1:0]     rd_units;
   logic [CNT_W-1:0]     free_dec;
   logic [CNT_W-1:0]     fill_nxt;
   logic [USZ_W-1:0]     usz;
   logic [PROD_W-1:0]    prod;
   logic                 rem_ge;
   logic [BLK_W-1:0]     top_blk;
   logic                 any_free;
   logic [ABLK_W-1:0]    req_ablk;
   logic                 req_in_pool;

   // Clamp a configured block size to the range one to MAX_UNITS.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_CFG_W-1:0] c);
      logic [CNT_W-1:0] r;
      if (c == '0) begin
         r = CNT_W'(1);
      end else if (32'(c) > MAX_UNITS) begin
         r = CNT_W'(MAX_UNITS);
      end else begin
         r = CNT_W'(c);
      end
      return r;
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unit_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   // Block table entry layout is {head, free count, unit count}.
   assign rd_head  = blk_rd_ff[BE_W-1 -: UNIT_W];
   assign rd_free  = blk_rd_ff[2*CNT_W-1 -: CNT_W];
   assign rd_units = blk_rd_ff[CNT_W-1:0];
   assign free_dec = rd_free - 1'b1;
   assign fill_nxt = fill_ff + 1'b1;

   // Effective unit size, held between two and sixteen bytes.
   always_comb begin
      if (unit_size_ff < USZ_MIN) begin
         usz = USZ_MIN;
      end else if (unit_size_ff > USZ_MAX) begin
         usz = USZ_MAX;
      end else begin
         usz = unit_size_ff;
      end
   end

   // Byte size of the block just read, for the pool bound check on free.
   assign prod   = PROD_W'(rd_units) * PROD_W'(usz);
   assign rem_ge = (rem_ff >= REM_W'(dsr_ff));

   // Block number of a free request and whether it names an open block.
   assign req_ablk    = req_address[ADDR_W-1:SPAN_W];
   assign req_in_pool = (32'(req_ablk) < 32'(bo_ff));

   // Newest block with a free unit: the highest set bit of the free vector.
   always_comb begin
      top_blk = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (has_free_ff[i]) begin
            top_blk = BLK_W'(i);
         end
      end
      any_free = |has_free_ff;
   end

   // Link reads always follow the head of the block being worked on.
   assign link_ra = {blk_ff, rd_head};

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_count_ff <= INIT_COUNT_RST;
         grow_count_ff <= GROW_COUNT_RST;
         unit_size_ff  <= UNIT_SIZE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INIT_COUNT: init_count_ff <= csr_wdata;
            CSR_GROW_COUNT: grow_count_ff <= csr_wdata;
            CSR_UNIT_SIZE:  unit_size_ff  <= csr_wdata[USZ_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state and pool control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bo_ff        <= '0;
         has_free_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bo_ff        <= bo_in;
         has_free_ff  <= has_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      blk_ff        <= blk_in;
      off_ff        <= off_in;
      units_ff      <= units_in;
      fill_ff       <= fill_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      ua_ff         <= ua_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Next state, memory accesses and response.
   always_comb begin
      state_in      = state_ff;
      blk_in        = blk_ff;
      bo_in         = bo_ff;
      has_free_in   = has_free_ff;
      off_in        = off_ff;
      units_in      = units_ff;
      fill_in       = fill_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      ua_in         = ua_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = ST_OK;
      blk_ra        = blk_ff;
      blk_we        = 1'b0;
      blk_wd        = blk_rd_ff;
      link_we       = 1'b0;
      link_wa       = link_ra;
      link_wd       = rd_head;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               off_in = req_address[SPAN_W-1:0];
               if (req_command == CMD_ALLOC) begin
                  if (any_free) begin
                     // Read the newest block that still has a unit.
                     blk_in   = top_blk;
                     blk_ra   = top_blk;
                     state_in = S_ALLOC_LINK;
                  end else if (32'(bo_ff) < MAX_BLOCKS) begin
                     // All open blocks full: open the next one.
                     blk_in   = BLK_W'(bo_ff);
                     fill_in  = '0;
                     units_in = clamp_count((bo_ff == '0) ? init_count_ff : grow_count_ff);
                     state_in = S_OPEN_FILL;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EXHAUSTED;
                  end
               end else begin
                  if (req_in_pool) begin
                     blk_in   = BLK_W'(req_ablk);
                     blk_ra   = BLK_W'(req_ablk);
                     state_in = S_FREE_CHK;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FOREIGN;
                  end
               end
            end
         end

         S_OPEN_FILL: begin
            // Chain the new block's units in order; the last link is zero.
            link_we = 1'b1;
            link_wa = {blk_ff, UNIT_W'(fill_ff)};
            link_wd = (fill_nxt < units_ff) ? UNIT_W'(fill_nxt) : '0;
            fill_in = fill_nxt;
            if (fill_nxt == units_ff) begin
               state_in = S_OPEN_WR;
            end
         end

         S_OPEN_WR: begin
            blk_we                = 1'b1;
            blk_wd                = {UNIT_W'(0), units_ff, units_ff};
            has_free_in[blk_ff]   = 1'b1;
            bo_in                 = bo_ff + 1'b1;
            state_in              = S_ALLOC_RD;
         end

         S_ALLOC_RD: begin
            state_in = S_ALLOC_LINK;
         end

         S_ALLOC_LINK: begin
            // Block entry is here; the head's link is read this cycle.
            ua_in    = (ADDR_W'(blk_ff) << SPAN_W) + ADDR_W'(rd_head) * ADDR_W'(usz);
            state_in = S_ALLOC_LINK == state_ff ? S_ALLOC_WB : state_ff;
         end

         S_ALLOC_WB: begin
            // Pop the head: the link becomes the new head.
            blk_we              = 1'b1;
            blk_wd              = {link_rd_ff, free_dec, rd_units};
            has_free_in[blk_ff] = (free_dec != '0);
            rsp_valid_in        = 1'b1;
            rsp_addr_in         = ua_ff;
            rsp_status_in       = ST_OK;
            state_in            = S_IDLE;
         end

         S_FREE_CHK: begin
            if ((32'(off_ff) >= 32'(prod)) || (rd_free >= rd_units)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FOREIGN;
               state_in      = S_IDLE;
            end else begin
               rem_in   = REM_W'(off_ff);
               dsr_in   = DSR_W'(usz) << (UNIT_W - 1);
               quo_in   = '0;
               step_in  = '0;
               state_in = S_FREE_DIV;
            end
         end

         S_FREE_DIV: begin
            // One quotient bit per cycle, most significant first.
            if (rem_ge) begin
               rem_in = rem_ff - REM_W'(dsr_ff);
            end
            quo_in  = (quo_ff << 1) | UNIT_W'(rem_ge);
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff + 1'b1;
            if (32'(step_ff) == UNIT_W - 1) begin
               state_in = S_FREE_WB;
            end
         end

         S_FREE_WB: begin
            // Push the unit: it links to the old head and becomes the head.
            link_we             = 1'b1;
            link_wa             = {blk_ff, quo_ff};
            link_wd             = rd_head;
            blk_we              = 1'b1;
            blk_wd              = {quo_ff, rd_free + 1'b1, rd_units};
            has_free_in[blk_ff] = 1'b1;
            rsp_valid_in        = 1'b1;
            rsp_status_in       = ST_OK;
            state_in            = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Block table memory.
   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem_ff[blk_ff] <= blk_wd;
      end
      blk_rd_ff <= blk_mem_ff[blk_ra];
   end

   // Free-list link memory.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem_ff[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem_ff[link_ra];
   end

   // The open block count never passes the pool size.
   a_bo_range: assert property (@(posedge clock) disable iff (reset)
      32'(bo_ff) <= MAX_BLOCKS)
      else $error("open block count beyond pool size");

   // Only open blocks can be marked as holding free units.
   a_free_open: assert property (@(posedge clock) disable iff (reset)
      (has_free_ff >> bo_ff) == '0)
      else $error("unopened block marked as having free units");

   // Exhaustion is reported only when every block is open and full.
   a_exhausted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_EXHAUSTED)) |->
      ((32'(bo_ff) == MAX_BLOCKS) && (has_free_ff == '0)))
      else $error("exhausted reported while units remain");

   // An accepted request either answers at once or keeps the block busy.
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither answered nor in progress");

   // The link fill stays inside the block being opened.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPEN_FILL) |-> (fill_ff < units_ff))
      else $error("block fill ran past its unit count");

endmodule
